// ----- hw/rtl/sd_card_init_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// SD card init sequencer assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_INIT_SEQUENCER_ASSERT_SVH
`define SD_CARD_INIT_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdi check failed");

// antecedent implies consequent in the next cycle
`define SDI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdi check failed");

`endif

// ----- hw/rtl/sdi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdi_pkg
// Types and constants of the SD/MMC card init sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdi_pkg;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_CMD0   = 4'd1,
		PH_CMD8   = 4'd2,
		PH_V2POLL = 4'd3,
		PH_PROBE  = 4'd4,
		PH_V1POLL = 4'd5,
		PH_CMD2   = 4'd6,
		PH_CMD3   = 4'd7,
		PH_CMD9   = 4'd8,
		PH_CMD7   = 4'd9,
		PH_CMD16  = 4'd10,
		PH_ACMD6  = 4'd11,
		PH_DONE   = 4'd12,
		PH_FAIL   = 4'd13
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  kind;
		logic        block;
		logic [15:0] addr;
		logic [3:0]  attempts;
		logic        prefix;
	} sdi_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  index;
		logic [31:0] argument;
		logic [1:0]  rkind;
		logic        restart;
	} sdi_cmd_t;

	localparam logic       OP_BEGIN   = 1'b0;

	localparam logic [1:0] OUT_OK     = 2'd0;
	localparam logic [1:0] OUT_CRC    = 2'd2;

	localparam logic [1:0] ACT_ISSUE  = 2'd0;
	localparam logic [1:0] ACT_DONE   = 2'd1;
	localparam logic [1:0] ACT_FAIL   = 2'd2;

	localparam logic [1:0] RK_NONE    = 2'd0;
	localparam logic [1:0] RK_SHORT   = 2'd1;
	localparam logic [1:0] RK_LONG    = 2'd2;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_MMC     = 2'd1;
	localparam logic [1:0] KIND_SD1     = 2'd2;
	localparam logic [1:0] KIND_SD2     = 2'd3;

	localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
	localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
	localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
	localparam logic [5:0] CMD_SET_RCA      = 6'd3;
	localparam logic [5:0] ACMD_SET_BUS     = 6'd6;
	localparam logic [5:0] CMD_SELECT       = 6'd7;
	localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
	localparam logic [5:0] CMD_STOP         = 6'd12;
	localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
	localparam logic [5:0] ACMD_SD_SEND_OP  = 6'd41;
	localparam logic [5:0] CMD_APP          = 6'd55;

	localparam logic [11:0] CHECK_PATTERN   = 12'h1aa;
	localparam logic [31:0] IF_COND_ARG     = 32'h0000_01aa;
	localparam logic [31:0] OCR_ARG_HCS     = 32'h40ff_8000;
	localparam logic [31:0] OCR_ARG         = 32'h00ff_8000;
	localparam logic [31:0] STATUS_ERR_MASK = 32'hfdf9_0000;
	localparam logic [31:0] BLOCK_LEN_ARG   = 32'd512;
	localparam logic [31:0] BUS_4BIT_ARG    = 32'd2;
	localparam logic [31:0] MMC_RCA_ARG     = 32'h0001_0000;
	localparam logic [15:0] MMC_RCA         = 16'd1;
	localparam int          APP_CMD_BIT     = 5;

	localparam logic [3:0] EXTRA_ATTEMPTS_RESET = 4'd4;

endpackage

`default_nettype wire

// ----- hw/rtl/sd_card_init_sequencer.sv -----
// An accepted item is held in the input stage until the output register can take it.
// Throughput: 1 item per cycle while the output is not stalled; input stage and
//   output register run concurrently, the sequencer state updates as an item moves out.
// Reset (arst_n low): sequencer idle, held card facts cleared, extra_attempts 4,
//   both stages empty.
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// SD/MMC card bring-up sequencer: one command request or verdict per accepted input.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_init_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  extra_attempts,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [1:0]  outcome,
	input  logic [31:0] response_word,
	input  logic        deadline_passed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [5:0]  command_index,
	output logic [31:0] command_argument,
	output logic [1:0]  response_kind,
	output logic        restart_timer,
	output logic [1:0]  card_kind,
	output logic        block_addressing,
	output logic [15:0] card_address,
	output logic        wide_bus
);

	logic [3:0]          extra_attempts_q;
	sdi_pkg::sdi_state_t state_q;
	sdi_pkg::sdi_state_t state_nxt;
	sdi_pkg::sdi_cmd_t   cmd_nxt;

	logic        valid_s1;
	logic        operation_s1;
	logic [1:0]  outcome_s1;
	logic [31:0] response_word_s1;
	logic        deadline_passed_s1;

	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [5:0]  command_index_q;
	logic [31:0] command_argument_q;
	logic [1:0]  response_kind_q;
	logic        restart_timer_q;
	logic [1:0]  card_kind_q;
	logic        block_addressing_q;
	logic [15:0] card_address_q;
	logic        wide_bus_q;

	logic advance;
	logic move;
	logic in_take;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign move      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_attempts_q <= sdi_pkg::EXTRA_ATTEMPTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			extra_attempts_q <= extra_attempts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (move)
				valid_s1 <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (move)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			operation_s1       <= operation;
			outcome_s1         <= outcome;
			response_word_s1   <= response_word;
			deadline_passed_s1 <= deadline_passed;
		end
		if (move) begin
			action_q           <= cmd_nxt.action;
			command_index_q    <= cmd_nxt.index;
			command_argument_q <= cmd_nxt.argument;
			response_kind_q    <= cmd_nxt.rkind;
			restart_timer_q    <= cmd_nxt.restart;
			card_kind_q        <= state_nxt.kind;
			block_addressing_q <= state_nxt.block;
			card_address_q     <= state_nxt.addr;
			wide_bus_q         <= (state_nxt.phase == sdi_pkg::PH_DONE) &&
				((state_nxt.kind == sdi_pkg::KIND_SD1) ||
				(state_nxt.kind == sdi_pkg::KIND_SD2));
		end
	end

	sdi_step u_step (
		.st              (state_q),
		.extra_attempts  (extra_attempts_q),
		.operation       (operation_s1),
		.outcome         (outcome_s1),
		.response_word   (response_word_s1),
		.deadline_passed (deadline_passed_s1),
		.nxt             (state_nxt),
		.cmd             (cmd_nxt)
	);

	assign out_valid        = out_valid_q;
	assign action           = action_q;
	assign command_index    = command_index_q;
	assign command_argument = command_argument_q;
	assign response_kind    = response_kind_q;
	assign restart_timer    = restart_timer_q;
	assign card_kind        = card_kind_q;
	assign block_addressing = block_addressing_q;
	assign card_address     = card_address_q;
	assign wide_bus         = wide_bus_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sdi_step.sv -----
// ----------------------------------------------------------------------------
// sdi_step
// Next-state and next-request logic for one reported command outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module sdi_step (
	input  sdi_pkg::sdi_state_t st,
	input  logic [3:0]          extra_attempts,
	input  logic                operation,
	input  logic [1:0]          outcome,
	input  logic [31:0]         response_word,
	input  logic                deadline_passed,
	output sdi_pkg::sdi_state_t nxt,
	output sdi_pkg::sdi_cmd_t   cmd
);

	function automatic logic cmd_ok(input logic [1:0] oc, input logic [5:0] ix);
		cmd_ok = (oc == sdi_pkg::OUT_OK) ||
			((oc == sdi_pkg::OUT_CRC) && ((ix == sdi_pkg::CMD_SEND_OP_COND) ||
			(ix == sdi_pkg::CMD_STOP) || (ix == sdi_pkg::ACMD_SD_SEND_OP)));
	endfunction

	function automatic sdi_pkg::sdi_cmd_t issue(input logic [5:0] ix,
		input logic [31:0] arg, input logic [1:0] rk);
		sdi_pkg::sdi_cmd_t c;
		c.action   = sdi_pkg::ACT_ISSUE;
		c.index    = ix;
		c.argument = arg;
		c.rkind    = rk;
		c.restart  = 1'b0;
		issue = c;
	endfunction

	function automatic sdi_pkg::sdi_cmd_t verdict(input logic [1:0] act);
		sdi_pkg::sdi_cmd_t c;
		c        = '0;
		c.action = act;
		verdict  = c;
	endfunction

	logic [5:0]  cur_idx;
	logic        good;
	logic        app_ok;
	logic        ready_bit;
	logic        status_err;
	logic        retry_fail;
	logic [3:0]  retry_attempts;
	logic [31:0] rca_arg;
	logic [5:0]  app_idx;
	logic [31:0] app_arg;
	logic        is_sd;

	always_comb begin
		case (st.phase)
			sdi_pkg::PH_CMD0:   cur_idx = sdi_pkg::CMD_GO_IDLE;
			sdi_pkg::PH_CMD8:   cur_idx = sdi_pkg::CMD_SEND_IF_COND;
			sdi_pkg::PH_V2POLL: cur_idx = sdi_pkg::ACMD_SD_SEND_OP;
			sdi_pkg::PH_PROBE:  cur_idx = sdi_pkg::ACMD_SD_SEND_OP;
			sdi_pkg::PH_V1POLL: cur_idx = (st.kind == sdi_pkg::KIND_MMC) ?
				sdi_pkg::CMD_SEND_OP_COND : sdi_pkg::ACMD_SD_SEND_OP;
			sdi_pkg::PH_CMD2:   cur_idx = sdi_pkg::CMD_ALL_SEND_CID;
			sdi_pkg::PH_CMD3:   cur_idx = sdi_pkg::CMD_SET_RCA;
			sdi_pkg::PH_CMD9:   cur_idx = sdi_pkg::CMD_SEND_CSD;
			sdi_pkg::PH_CMD7:   cur_idx = sdi_pkg::CMD_SELECT;
			sdi_pkg::PH_CMD16:  cur_idx = sdi_pkg::CMD_SET_BLOCKLEN;
			default:            cur_idx = sdi_pkg::ACMD_SET_BUS;
		endcase
	end

	assign app_ok         = cmd_ok(outcome, sdi_pkg::CMD_APP) &&
		response_word[sdi_pkg::APP_CMD_BIT];
	assign good           = !st.prefix && cmd_ok(outcome, cur_idx);
	assign ready_bit      = response_word[31];
	assign status_err     = |(response_word & sdi_pkg::STATUS_ERR_MASK);
	assign retry_fail     = deadline_passed && (st.attempts == 4'd0);
	assign retry_attempts = deadline_passed ? 4'(st.attempts - 4'd1) : st.attempts;
	assign rca_arg        = {st.addr, 16'h0000};
	assign is_sd          = (st.kind == sdi_pkg::KIND_SD1) || (st.kind == sdi_pkg::KIND_SD2);
	assign app_idx        = (st.phase == sdi_pkg::PH_ACMD6) ?
		sdi_pkg::ACMD_SET_BUS : sdi_pkg::ACMD_SD_SEND_OP;

	always_comb begin
		if (st.phase == sdi_pkg::PH_ACMD6)
			app_arg = sdi_pkg::BUS_4BIT_ARG;
		else if (st.phase == sdi_pkg::PH_V2POLL)
			app_arg = sdi_pkg::OCR_ARG_HCS;
		else
			app_arg = sdi_pkg::OCR_ARG;
	end

	always_comb begin
		nxt = st;
		cmd = verdict(sdi_pkg::ACT_FAIL);
		if (operation == sdi_pkg::OP_BEGIN) begin
			nxt       = '0;
			nxt.phase = sdi_pkg::PH_CMD0;
			cmd       = issue(sdi_pkg::CMD_GO_IDLE, 32'h0, sdi_pkg::RK_NONE);
		end else if (st.prefix && app_ok && st.phase != sdi_pkg::PH_IDLE &&
			st.phase != sdi_pkg::PH_DONE && st.phase != sdi_pkg::PH_FAIL) begin
			nxt.prefix = 1'b0;
			cmd        = issue(app_idx, app_arg, sdi_pkg::RK_SHORT);
		end else begin
			case (st.phase)
				sdi_pkg::PH_CMD0: begin
					if (good) begin
						nxt.attempts = extra_attempts;
						nxt.phase    = sdi_pkg::PH_CMD8;
						cmd = issue(sdi_pkg::CMD_SEND_IF_COND, sdi_pkg::IF_COND_ARG,
							sdi_pkg::RK_SHORT);
						cmd.restart  = 1'b1;
					end
				end
				sdi_pkg::PH_CMD8: begin
					nxt.phase  = (good && response_word[11:0] == sdi_pkg::CHECK_PATTERN) ?
						sdi_pkg::PH_V2POLL : sdi_pkg::PH_PROBE;
					nxt.prefix = 1'b1;
					cmd = issue(sdi_pkg::CMD_APP, rca_arg, sdi_pkg::RK_SHORT);
				end
				sdi_pkg::PH_V2POLL: begin
					if (good && ready_bit) begin
						nxt.kind   = sdi_pkg::KIND_SD2;
						nxt.block  = response_word[30];
						nxt.phase  = sdi_pkg::PH_CMD2;
						nxt.prefix = 1'b0;
						cmd = issue(sdi_pkg::CMD_ALL_SEND_CID, 32'h0, sdi_pkg::RK_LONG);
					end else if (!retry_fail) begin
						nxt.attempts = retry_attempts;
						nxt.prefix   = 1'b1;
						cmd = issue(sdi_pkg::CMD_APP, rca_arg, sdi_pkg::RK_SHORT);
					end
				end
				sdi_pkg::PH_PROBE: begin
					nxt.phase = sdi_pkg::PH_V1POLL;
					if (good) begin
						nxt.kind   = sdi_pkg::KIND_SD1;
						nxt.prefix = 1'b1;
						cmd = issue(sdi_pkg::CMD_APP, rca_arg, sdi_pkg::RK_SHORT);
					end else begin
						nxt.kind   = sdi_pkg::KIND_MMC;
						nxt.prefix = 1'b0;
						cmd = issue(sdi_pkg::CMD_SEND_OP_COND, sdi_pkg::OCR_ARG,
							sdi_pkg::RK_SHORT);
					end
				end
				sdi_pkg::PH_V1POLL: begin
					nxt.prefix = 1'b0;
					if (good && ready_bit) begin
						nxt.phase = sdi_pkg::PH_CMD2;
						cmd = issue(sdi_pkg::CMD_ALL_SEND_CID, 32'h0, sdi_pkg::RK_LONG);
					end else if (!retry_fail) begin
						nxt.attempts = retry_attempts;
						if (st.kind == sdi_pkg::KIND_MMC) begin
							cmd = issue(sdi_pkg::CMD_SEND_OP_COND, sdi_pkg::OCR_ARG,
								sdi_pkg::RK_SHORT);
						end else begin
							nxt.prefix = 1'b1;
							cmd = issue(sdi_pkg::CMD_APP, rca_arg, sdi_pkg::RK_SHORT);
						end
					end
				end
				sdi_pkg::PH_CMD2: begin
					if (good) begin
						nxt.phase = sdi_pkg::PH_CMD3;
						cmd = issue(sdi_pkg::CMD_SET_RCA,
							(st.kind == sdi_pkg::KIND_MMC) ? sdi_pkg::MMC_RCA_ARG : 32'h0,
							sdi_pkg::RK_SHORT);
					end
				end
				sdi_pkg::PH_CMD3: begin
					if (good) begin
						nxt.addr  = (st.kind == sdi_pkg::KIND_MMC) ?
							sdi_pkg::MMC_RCA : response_word[31:16];
						nxt.phase = sdi_pkg::PH_CMD9;
						cmd = issue(sdi_pkg::CMD_SEND_CSD, {nxt.addr, 16'h0000},
							sdi_pkg::RK_LONG);
					end
				end
				sdi_pkg::PH_CMD9: begin
					if (good) begin
						nxt.phase = sdi_pkg::PH_CMD7;
						cmd = issue(sdi_pkg::CMD_SELECT, rca_arg, sdi_pkg::RK_SHORT);
					end
				end
				sdi_pkg::PH_CMD7, sdi_pkg::PH_CMD16: begin
					if (good && st.phase == sdi_pkg::PH_CMD7 && !st.block) begin
						nxt.phase = sdi_pkg::PH_CMD16;
						cmd = issue(sdi_pkg::CMD_SET_BLOCKLEN, sdi_pkg::BLOCK_LEN_ARG,
							sdi_pkg::RK_SHORT);
					end else if (good && !(st.phase == sdi_pkg::PH_CMD16 && status_err)) begin
						if (is_sd) begin
							nxt.phase  = sdi_pkg::PH_ACMD6;
							nxt.prefix = 1'b1;
							cmd = issue(sdi_pkg::CMD_APP, rca_arg, sdi_pkg::RK_SHORT);
						end else begin
							nxt.phase = sdi_pkg::PH_DONE;
							cmd       = verdict(sdi_pkg::ACT_DONE);
						end
					end
				end
				sdi_pkg::PH_ACMD6: begin
					if (good && !status_err) begin
						nxt.phase = sdi_pkg::PH_DONE;
						cmd       = verdict(sdi_pkg::ACT_DONE);
					end
				end
				sdi_pkg::PH_DONE: begin
					cmd = verdict(sdi_pkg::ACT_DONE);
				end
				default: begin
					cmd = verdict(sdi_pkg::ACT_FAIL);
				end
			endcase
			// any failing branch above left the fail verdict in place
			if (cmd.action == sdi_pkg::ACT_FAIL && st.phase != sdi_pkg::PH_IDLE &&
				st.phase != sdi_pkg::PH_FAIL && st.phase != sdi_pkg::PH_DONE &&
				st.phase <= sdi_pkg::PH_ACMD6) begin
				nxt        = st;
				nxt.phase  = sdi_pkg::PH_FAIL;
				nxt.prefix = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sdi_checker.sv -----
// ----------------------------------------------------------------------------
// sdi_checker
// Port-level checks of the card init sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_card_init_sequencer_assert.svh"

module sdi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  action,
	input logic [5:0]  command_index,
	input logic [31:0] command_argument,
	input logic [1:0]  response_kind,
	input logic        restart_timer,
	input logic [1:0]  card_kind,
	input logic        wide_bus
);

	`SDI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(action) && $stable(command_index) && $stable(command_argument))

	`SDI_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

	`SDI_ASSERT_SAME(a_verdict_clean, out_valid && action != sdi_pkg::ACT_ISSUE,
		command_index == 6'd0 && command_argument == 32'h0 &&
		response_kind == sdi_pkg::RK_NONE && !restart_timer)

	`SDI_ASSERT_SAME(a_timer_cmd8, out_valid && restart_timer,
		action == sdi_pkg::ACT_ISSUE && command_index == sdi_pkg::CMD_SEND_IF_COND &&
		card_kind == sdi_pkg::KIND_UNKNOWN)

	`SDI_ASSERT_SAME(a_wide_sd_done, out_valid && wide_bus,
		action == sdi_pkg::ACT_DONE &&
		(card_kind == sdi_pkg::KIND_SD1 || card_kind == sdi_pkg::KIND_SD2))

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the SD/MMC init sequencer. It scripts card sessions for SD v2,
// SD v1 and MMC cards, with injected faults, cut-short sessions and random
// noise. A built-in copy of the bring-up sequence predicts every command or
// verdict, and each result is checked field by field. Both handshakes idle
// at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	import sdi_pkg::*;

	localparam logic       OP_OUTCOME   = 1'b1;
	localparam logic [1:0] OUT_TIMEOUT  = 2'd1;
	localparam logic [1:0] OUT_RESERVED = 2'd3;

	typedef struct packed {
		logic        op;
		logic [1:0]  oc;
		logic [31:0] resp;
		logic        dl;
	} card_req_t;

	typedef struct packed {
		sdi_cmd_t    cmd;
		logic [1:0]  kind;
		logic        block;
		logic [15:0] addr;
		logic        wide;
	} card_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  extra_attempts = EXTRA_ATTEMPTS_RESET;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_BEGIN;
	logic [1:0]  outcome = OUT_OK;
	logic [31:0] response_word = '0;
	logic        deadline_passed = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  action;
	logic [5:0]  command_index;
	logic [31:0] command_argument;
	logic [1:0]  response_kind;
	logic        restart_timer;
	logic [1:0]  card_kind;
	logic        block_addressing;
	logic [15:0] card_address;
	logic        wide_bus;

	// sequencer copy; declaration values are the reset state
	phase_t      seq_phase = PH_IDLE;
	logic [1:0]  seq_kind = KIND_UNKNOWN;
	logic        seq_block = 1'b0;
	logic [15:0] seq_addr = '0;
	logic [3:0]  seq_attempts = '0;
	logic        seq_prefix = 1'b0;
	logic [3:0]  seq_extra = EXTRA_ATTEMPTS_RESET;

	card_req_t   outcome_q[$];
	card_reply_t next_cmd_q[$];
	card_req_t   shown_req;
	card_reply_t seen_cmd;
	card_reply_t want_cmd;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_left = 0;
	logic hold_request = 1'b0;
	logic stall_next;
	int gen_left = 0;
	int n_items = 0;
	int n_sessions = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_done = 0;
	int n_failed = 0;
	int n_errors = 0;

	always #5 clk = ~clk;

	sd_card_init_sequencer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.extra_attempts   (extra_attempts),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.outcome          (outcome),
		.response_word    (response_word),
		.deadline_passed  (deadline_passed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.command_index    (command_index),
		.command_argument (command_argument),
		.response_kind    (response_kind),
		.restart_timer    (restart_timer),
		.card_kind        (card_kind),
		.block_addressing (block_addressing),
		.card_address     (card_address),
		.wide_bus         (wide_bus)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= 40)
			$display("tb_top: mismatch on %s at result %0d: got %h, expected %h",
				what, n_results, got, want);
	endtask

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [1:0] any_oc();
		return 2'($urandom_range(0, 3));
	endfunction

	// ---- sequencer prediction ----

	function automatic logic cmd_good(input logic [1:0] oc, input logic [5:0] idx);
		return oc == OUT_OK || (oc == OUT_CRC && (idx == CMD_SEND_OP_COND ||
			idx == CMD_STOP || idx == ACMD_SD_SEND_OP));
	endfunction

	task automatic post_cmd(input logic [1:0] act, input logic [5:0] idx,
			input logic [31:0] arg, input logic [1:0] rk, input logic rs);
		card_reply_t c;
		c.cmd.action = act;
		c.cmd.index = idx;
		c.cmd.argument = arg;
		c.cmd.rkind = rk;
		c.cmd.restart = rs;
		c.kind = seq_kind;
		c.block = seq_block;
		c.addr = seq_addr;
		c.wide = seq_phase == PH_DONE && (seq_kind == KIND_SD1 || seq_kind == KIND_SD2);
		next_cmd_q.push_back(c);
	endtask

	task automatic seq_fail();
		seq_phase = PH_FAIL;
		seq_prefix = 1'b0;
		post_cmd(ACT_FAIL, CMD_GO_IDLE, '0, RK_NONE, 1'b0);
	endtask

	task automatic seq_app(input phase_t p);
		seq_phase = p;
		seq_prefix = 1'b1;
		post_cmd(ACT_ISSUE, CMD_APP, {seq_addr, 16'h0}, RK_SHORT, 1'b0);
	endtask

	task automatic seq_poll(input phase_t p);
		if (p == PH_V1POLL && seq_kind == KIND_MMC) begin
			seq_phase = p;
			post_cmd(ACT_ISSUE, CMD_SEND_OP_COND, OCR_ARG, RK_SHORT, 1'b0);
		end else begin
			seq_app(p);
		end
	endtask

	task automatic seq_retry(input logic dl);
		if (dl) begin
			if (seq_attempts == 0) begin
				seq_fail();
				return;
			end
			seq_attempts = seq_attempts - 4'd1;
		end
		seq_poll(seq_phase);
	endtask

	task automatic seq_after_select();
		if (seq_kind == KIND_SD1 || seq_kind == KIND_SD2) begin
			seq_app(PH_ACMD6);
		end else begin
			seq_phase = PH_DONE;
			post_cmd(ACT_DONE, CMD_GO_IDLE, '0, RK_NONE, 1'b0);
		end
	endtask

	task automatic sequence_card(input card_req_t r);
		logic       good;
		logic [5:0] idx;
		if (r.op == OP_BEGIN) begin
			seq_kind = KIND_UNKNOWN;
			seq_block = 1'b0;
			seq_addr = '0;
			seq_attempts = '0;
			seq_prefix = 1'b0;
			seq_phase = PH_CMD0;
			post_cmd(ACT_ISSUE, CMD_GO_IDLE, '0, RK_NONE, 1'b0);
			return;
		end
		if (seq_phase == PH_IDLE || seq_phase == PH_DONE || seq_phase == PH_FAIL) begin
			post_cmd(seq_phase == PH_DONE ? ACT_DONE : ACT_FAIL, CMD_GO_IDLE, '0,
				RK_NONE, 1'b0);
			return;
		end
		if (seq_prefix) begin
			seq_prefix = 1'b0;
			if (cmd_good(r.oc, CMD_APP) && r.resp[APP_CMD_BIT]) begin
				post_cmd(ACT_ISSUE,
					seq_phase == PH_ACMD6 ? ACMD_SET_BUS : ACMD_SD_SEND_OP,
					seq_phase == PH_ACMD6 ? BUS_4BIT_ARG :
					seq_phase == PH_V2POLL ? OCR_ARG_HCS : OCR_ARG,
					RK_SHORT, 1'b0);
				return;
			end
			good = 1'b0;
		end else begin
			case (seq_phase)
				PH_CMD0:             idx = CMD_GO_IDLE;
				PH_CMD8:             idx = CMD_SEND_IF_COND;
				PH_V2POLL, PH_PROBE: idx = ACMD_SD_SEND_OP;
				PH_V1POLL:           idx = seq_kind == KIND_MMC ? CMD_SEND_OP_COND :
					ACMD_SD_SEND_OP;
				PH_CMD2:             idx = CMD_ALL_SEND_CID;
				PH_CMD3:             idx = CMD_SET_RCA;
				PH_CMD9:             idx = CMD_SEND_CSD;
				PH_CMD7:             idx = CMD_SELECT;
				PH_CMD16:            idx = CMD_SET_BLOCKLEN;
				default:             idx = ACMD_SET_BUS;
			endcase
			good = cmd_good(r.oc, idx);
		end
		case (seq_phase)
			PH_CMD0: begin
				if (!good) begin
					seq_fail();
				end else begin
					seq_attempts = seq_extra;
					seq_phase = PH_CMD8;
					post_cmd(ACT_ISSUE, CMD_SEND_IF_COND, IF_COND_ARG, RK_SHORT, 1'b1);
				end
			end
			PH_CMD8: begin
				if (good && r.resp[11:0] == CHECK_PATTERN)
					seq_app(PH_V2POLL);
				else
					seq_app(PH_PROBE);
			end
			PH_V2POLL: begin
				if (good && r.resp[31]) begin
					seq_kind = KIND_SD2;
					seq_block = r.resp[30];
					seq_phase = PH_CMD2;
					post_cmd(ACT_ISSUE, CMD_ALL_SEND_CID, '0, RK_LONG, 1'b0);
				end else begin
					seq_retry(r.dl);
				end
			end
			PH_PROBE: begin
				seq_kind = good ? KIND_SD1 : KIND_MMC;
				seq_poll(PH_V1POLL);
			end
			PH_V1POLL: begin
				if (good && r.resp[31]) begin
					seq_phase = PH_CMD2;
					post_cmd(ACT_ISSUE, CMD_ALL_SEND_CID, '0, RK_LONG, 1'b0);
				end else begin
					seq_retry(r.dl);
				end
			end
			PH_CMD2: begin
				if (!good) begin
					seq_fail();
				end else begin
					seq_phase = PH_CMD3;
					post_cmd(ACT_ISSUE, CMD_SET_RCA, seq_kind == KIND_MMC ? MMC_RCA_ARG : '0,
						RK_SHORT, 1'b0);
				end
			end
			PH_CMD3: begin
				if (!good) begin
					seq_fail();
				end else begin
					seq_addr = seq_kind == KIND_MMC ? MMC_RCA : r.resp[31:16];
					seq_phase = PH_CMD9;
					post_cmd(ACT_ISSUE, CMD_SEND_CSD, {seq_addr, 16'h0}, RK_LONG, 1'b0);
				end
			end
			PH_CMD9: begin
				if (!good) begin
					seq_fail();
				end else begin
					seq_phase = PH_CMD7;
					post_cmd(ACT_ISSUE, CMD_SELECT, {seq_addr, 16'h0}, RK_SHORT, 1'b0);
				end
			end
			PH_CMD7: begin
				if (!good) begin
					seq_fail();
				end else if (!seq_block) begin
					seq_phase = PH_CMD16;
					post_cmd(ACT_ISSUE, CMD_SET_BLOCKLEN, BLOCK_LEN_ARG, RK_SHORT, 1'b0);
				end else begin
					seq_after_select();
				end
			end
			PH_CMD16: begin
				if (!good || (r.resp & STATUS_ERR_MASK) != 0)
					seq_fail();
				else
					seq_after_select();
			end
			default: begin
				if (!good || (r.resp & STATUS_ERR_MASK) != 0) begin
					seq_fail();
				end else begin
					seq_phase = PH_DONE;
					post_cmd(ACT_DONE, CMD_GO_IDLE, '0, RK_NONE, 1'b0);
				end
			end
		endcase
	endtask

	// ---- stimulus ----

	task automatic push_req(input logic op, input logic [1:0] oc, input logic [31:0] resp,
			input logic dl);
		card_req_t r;
		r.op = op;
		r.oc = oc;
		r.resp = resp;
		r.dl = dl;
		outcome_q.push_back(r);
		n_items++;
	endtask

	// session outcomes stop once the cut-off budget is spent
	task automatic add_outcome(input logic [1:0] oc, input logic [31:0] resp, input logic dl);
		if (gen_left > 0) begin
			push_req(OP_OUTCOME, oc, resp, dl);
			gen_left--;
		end
	endtask

	function automatic logic [1:0] pick_oc(input int fault);
		logic [1:0] oc;
		oc = OUT_OK;
		if ($urandom_range(0, 99) < fault)
			oc = 2'($urandom_range(1, 3));
		return oc;
	endfunction

	function automatic logic [31:0] status_word(input int fault);
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 99) >= fault)
			w = w & ~STATUS_ERR_MASK;
		return w;
	endfunction

	task automatic add_app(input int fault);
		logic [31:0] w;
		w = $urandom;
		w[APP_CMD_BIT] = $urandom_range(0, 99) >= fault;
		add_outcome(pick_oc(fault), w, coin());
	endtask

	// route 0 SD v2, 1 SD v1, 2 MMC
	task automatic add_session(input int fault);
		int          route;
		int          polls;
		int          i;
		logic [31:0] w;
		logic [1:0]  oc;
		logic        bm;
		route = $urandom_range(0, 2);
		gen_left = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 14) : 1000;
		n_sessions++;
		push_req(OP_BEGIN, any_oc(), $urandom, coin());
		add_outcome(pick_oc(fault), $urandom, coin());
		w = $urandom;
		if (route == 0) begin
			w[11:0] = CHECK_PATTERN;
			add_outcome(pick_oc(fault), w, coin());
		end else begin
			if (w[11:0] == CHECK_PATTERN)
				w[0] = ~w[0];
			add_outcome($urandom_range(0, 1) ? OUT_TIMEOUT : OUT_OK, w, coin());
			add_app(fault);
			if (route == 1)
				oc = $urandom_range(0, 1) ? OUT_CRC : OUT_OK;
			else
				oc = $urandom_range(0, 1) ? OUT_TIMEOUT : OUT_RESERVED;
			add_outcome(oc, $urandom, coin());
		end
		polls = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
		for (i = 0; i <= polls; i++) begin
			if (route != 2)
				add_app(fault);
			w = $urandom;
			w[31] = i == polls;
			oc = pick_oc(fault);
			if (oc == OUT_OK && $urandom_range(0, 1))
				oc = OUT_CRC;
			add_outcome(oc, w, i < polls && $urandom_range(0, 2) == 0);
		end
		bm = route == 0 ? w[30] : 1'b0;
		add_outcome(pick_oc(fault), $urandom, coin());
		add_outcome(pick_oc(fault), $urandom, coin());
		add_outcome(pick_oc(fault), $urandom, coin());
		add_outcome(pick_oc(fault), $urandom, coin());
		if (!bm)
			add_outcome(pick_oc(fault), status_word(fault), coin());
		if (route != 2) begin
			add_app(fault);
			add_outcome(pick_oc(fault), status_word(fault), coin());
		end
		for (i = $urandom_range(0, 2); i > 0; i--)
			add_outcome(any_oc(), $urandom, coin());
	endtask

	task automatic write_attempts(input logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		extra_attempts <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seq_extra = val;
	endtask

	task automatic wait_drained();
		int spins;
		spins = 0;
		while ((outcome_q.size() != 0 || in_valid || next_cmd_q.size() != 0) &&
				spins < 200000) begin
			@(negedge clk);
			spins++;
		end
		repeat (4) @(negedge clk);
	endtask

	// ---- request driver ----

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_BEGIN;
			outcome <= OUT_OK;
			response_word <= '0;
			deadline_passed <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				sequence_card(shown_req);
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap == 0 && in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct)
					in_gap = $urandom_range(1, 18);
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (outcome_q.size() > 0) begin
					shown_req = outcome_q.pop_front();
					in_valid <= 1'b1;
					operation <= shown_req.op;
					outcome <= shown_req.oc;
					response_word <= shown_req.resp;
					deadline_passed <= shown_req.dl;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- long receiver hold-off ----

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_request)
			hold_left <= 80;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// ---- result monitor ----

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_cmd.cmd.action = action;
				seen_cmd.cmd.index = command_index;
				seen_cmd.cmd.argument = command_argument;
				seen_cmd.cmd.rkind = response_kind;
				seen_cmd.cmd.restart = restart_timer;
				seen_cmd.kind = card_kind;
				seen_cmd.block = block_addressing;
				seen_cmd.addr = card_address;
				seen_cmd.wide = wide_bus;
				n_results++;
				if (action == ACT_DONE)
					n_done++;
				else if (action == ACT_FAIL)
					n_failed++;
				if (next_cmd_q.size() == 0) begin
					report_mismatch("unrequested result, action", 32'(action), '0);
				end else begin
					want_cmd = next_cmd_q.pop_front();
					if (seen_cmd.cmd.action !== want_cmd.cmd.action)
						report_mismatch("action", 32'(seen_cmd.cmd.action),
							32'(want_cmd.cmd.action));
					if (seen_cmd.cmd.index !== want_cmd.cmd.index)
						report_mismatch("command_index", 32'(seen_cmd.cmd.index),
							32'(want_cmd.cmd.index));
					if (seen_cmd.cmd.argument !== want_cmd.cmd.argument)
						report_mismatch("command_argument", seen_cmd.cmd.argument,
							want_cmd.cmd.argument);
					if (seen_cmd.cmd.rkind !== want_cmd.cmd.rkind)
						report_mismatch("response_kind", 32'(seen_cmd.cmd.rkind),
							32'(want_cmd.cmd.rkind));
					if (seen_cmd.cmd.restart !== want_cmd.cmd.restart)
						report_mismatch("restart_timer", 32'(seen_cmd.cmd.restart),
							32'(want_cmd.cmd.restart));
					if (seen_cmd.kind !== want_cmd.kind)
						report_mismatch("card_kind", 32'(seen_cmd.kind), 32'(want_cmd.kind));
					if (seen_cmd.block !== want_cmd.block)
						report_mismatch("block_addressing", 32'(seen_cmd.block),
							32'(want_cmd.block));
					if (seen_cmd.addr !== want_cmd.addr)
						report_mismatch("card_address", 32'(seen_cmd.addr), 32'(want_cmd.addr));
					if (seen_cmd.wide !== want_cmd.wide)
						report_mismatch("wide_bus", 32'(seen_cmd.wide), 32'(want_cmd.wide));
				end
			end
			if (hold_left > 0) begin
				stall_next = 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				stall_next = 1'b1;
			end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
				out_gap = $urandom_range(1, 18) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	// ---- test sequence ----

	initial begin
		int         i;
		int         target;
		int         fault;
		logic [3:0] attempts_val;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		in_idle_pct = 20;
		out_idle_pct = 20;

		// outcome before any start
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		// CMD0 with the reserved outcome code
		push_req(OP_BEGIN, OUT_RESERVED, 32'hffff_ffff, 1'b1);
		push_req(OP_OUTCOME, OUT_RESERVED, 32'hffff_ffff, 1'b1);
		// SD v2, block addressed: deadline retry, APP_CMD bit missing, CRC on ACMD41
		push_req(OP_BEGIN, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, {20'h0, CHECK_PATTERN}, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0000_0020, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b1);
		push_req(OP_OUTCOME, OUT_OK, 32'hffff_ffdf, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'hffff_ffff, 1'b0);
		push_req(OP_OUTCOME, OUT_CRC, 32'hc000_0000, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'hffff_0000, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0000_0020, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0206_ffff, 1'b0);
		push_req(OP_OUTCOME, OUT_TIMEOUT, 32'h0, 1'b1);
		// MMC, byte addressed, status error on CMD16
		push_req(OP_BEGIN, OUT_CRC, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_TIMEOUT, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0000_0020, 1'b0);
		push_req(OP_OUTCOME, OUT_TIMEOUT, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_CRC, 32'h8000_0000, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0, 1'b0);
		push_req(OP_OUTCOME, OUT_OK, 32'h0001_0000, 1'b0);

		for (i = 0; i < 5; i++) begin
			wait_drained();
			case (i)
				0:       attempts_val = 4'd0;
				1:       attempts_val = 4'd15;
				2:       attempts_val = 4'($urandom_range(1, 14));
				3:       attempts_val = 4'd1;
				default: attempts_val = EXTRA_ATTEMPTS_RESET;
			endcase
			write_attempts(attempts_val);
			@(negedge clk);
			case (i)
				0:       begin in_idle_pct = 20; out_idle_pct = 20; end
				1:       begin in_idle_pct = 35; out_idle_pct = 5;  end
				2:       begin in_idle_pct = 5;  out_idle_pct = 35; end
				3:       begin in_idle_pct = 0;  out_idle_pct = 15; end
				default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
			endcase
			fault = $urandom_range(3, 15);
			target = n_items + 385;
			while (n_items < target) begin
				if ($urandom_range(0, 99) < 8) begin
					repeat ($urandom_range(1, 4))
						push_req(coin(), any_oc(), $urandom, coin());
				end else begin
					add_session(fault);
				end
			end
			if (i == 2) begin
				repeat (5) @(negedge clk);
				hold_request = 1'b1;
				@(negedge clk);
				hold_request = 1'b0;
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (next_cmd_q.size() != 0)
			report_mismatch("results never seen", 32'(next_cmd_q.size()), '0);
		$display("tb_top: %0d requests over %0d scripted card sessions plus noise, %0d results",
			n_accepted, n_sessions, n_results);
		$display("tb_top: %0d done and %0d failed verdicts, extra_attempts swept 0 to 15",
			n_done, n_failed);
		if (n_errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: timeout");
		$display("tb_top: errors");
		$finish;
	end

endmodule

// ----- sd_card_init_sequencer.f -----
+incdir+hw/rtl
hw/rtl/sdi_pkg.sv
hw/rtl/sdi_step.sv
hw/rtl/sd_card_init_sequencer.sv
hw/rtl/sdi_checker.sv
bench/tb_top.sv
